>>> src/ena_pkg.sv
// Shared widths, constants and stage payload types for the error norm accumulator.
`default_nettype none

package ena_pkg;

    // Sample and statistic widths
    localparam int SAMPLE_W  = 24;
    localparam int SUM1_W    = 40;
    localparam int SUM2_W    = 63;
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int THR_W     = 16;
    localparam int TEST_W    = 40;
    localparam int CNT_OUT_W = 17;

    // Threshold register reset: 1.0 percent with eight fraction bits
    localparam logic [THR_W-1:0] THR_RESET = 16'd256;

    // 100 percent scaled by the eight threshold fraction bits
    localparam logic [TEST_W-1:0] PCT_SCALE = 40'd25600;

    // Extremes of a signed sample
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SAMPLE_W-1:0]        umag_t;

    // Difference stage output
    typedef struct packed {
        umag_t   err;
        umag_t   mag;
        sample_t second;
        logic    last;
    } diff_t;

    // Product stage output
    typedef struct packed {
        umag_t             err;
        umag_t             mag;
        sample_t           second;
        logic [SQ_W-1:0]   err_sq;
        logic [SQ_W-1:0]   mag_sq;
        logic [TEST_W-1:0] err_scaled;
        logic [TEST_W-1:0] thr_mag;
        logic              mag_zero;
        logic              thr_zero;
        logic              last;
    } prod_t;

    // Statistics of one finished set
    typedef struct packed {
        umag_t                max_abs_error;
        umag_t                max_magnitude;
        logic [SUM1_W-1:0]    sum_abs_error;
        logic [SUM2_W-1:0]    sum_sq_error;
        logic [SUM1_W-1:0]    sum_magnitude;
        logic [SUM2_W-1:0]    sum_sq_magnitude;
        sample_t              min_second;
        sample_t              max_second;
        logic [CNT_OUT_W-1:0] item_count;
        logic [CNT_OUT_W-1:0] over_threshold_count;
        logic                 saturated;
    } result_t;

endpackage

`default_nettype wire

>>> src/error_norm_accumulator_unit.sv
// Top level of the error norm accumulator: threshold register and stage chain.
//
//  Channel  | Signals                                        | Direction
//  ---------+------------------------------------------------+----------
//  config   | cfg_we, cfg_wdata (threshold_percent)           | in
//  input    | in_valid/in_ready, first_value, second_value,   | in
//           | last_of_set                                     |
//  result   | out_valid/out_ready, eleven statistic fields    | out
//
//  One sample pair is accepted per cycle while in_ready is high. The result
//  of a set is registered after its last pair passes the input, difference
//  and product registers and the accumulate stage, which sets the rate: it
//  takes one transaction per cycle, but an unclaimed result stalls only the
//  next last pair there; the stall then backs up stage by stage to in_ready.
//  Reset clears all accumulators and loads the threshold with 1.0 percent.
`default_nettype none

module error_norm_accumulator_unit #(
    parameter int MAX_SET_ITEMS = 65536
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ena_pkg::THR_W-1:0]             cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ena_pkg::SAMPLE_W-1:0]   first_value,
    input  logic signed [ena_pkg::SAMPLE_W-1:0]   second_value,
    input  logic                                  last_of_set,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ena_pkg::SAMPLE_W-1:0]          max_abs_error,
    output logic [ena_pkg::SAMPLE_W-1:0]          max_magnitude,
    output logic [ena_pkg::SUM1_W-1:0]            sum_abs_error,
    output logic [ena_pkg::SUM2_W-1:0]            sum_sq_error,
    output logic [ena_pkg::SUM1_W-1:0]            sum_magnitude,
    output logic [ena_pkg::SUM2_W-1:0]            sum_sq_magnitude,
    output logic signed [ena_pkg::SAMPLE_W-1:0]   min_second,
    output logic signed [ena_pkg::SAMPLE_W-1:0]   max_second,
    output logic [ena_pkg::CNT_OUT_W-1:0]         item_count,
    output logic [ena_pkg::CNT_OUT_W-1:0]         over_threshold_count,
    output logic                                  saturated
);
    import ena_pkg::*;

    logic [THR_W-1:0] threshold_reg;
    logic             dif_valid;
    logic             dif_ready;
    diff_t            dif_item;
    logic             prod_valid;
    logic             prod_ready;
    prod_t            prod_item;
    result_t          result;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    ena_diff u_diff (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_value  (first_value),
        .second_value (second_value),
        .last_of_set  (last_of_set),
        .out_valid    (dif_valid),
        .out_ready    (dif_ready),
        .out_item     (dif_item)
    );

    ena_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dif_valid),
        .in_ready  (dif_ready),
        .in_item   (dif_item),
        .threshold (threshold_reg),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_item  (prod_item)
    );

    ena_accum #(
        .MAX_SET_ITEMS (MAX_SET_ITEMS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_item   (prod_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (result)
    );

    // Split the result into its ports
    assign max_abs_error        = result.max_abs_error;
    assign max_magnitude        = result.max_magnitude;
    assign sum_abs_error        = result.sum_abs_error;
    assign sum_sq_error         = result.sum_sq_error;
    assign sum_magnitude        = result.sum_magnitude;
    assign sum_sq_magnitude     = result.sum_sq_magnitude;
    assign min_second           = result.min_second;
    assign max_second           = result.max_second;
    assign item_count           = result.item_count;
    assign over_threshold_count = result.over_threshold_count;
    assign saturated            = result.saturated;

`ifndef SYNTHESIS
    // A set holds at least one pair, so its extremes are ordered
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_second <= max_second))
        else $error("min_second above max_second");

    // Pairs over the threshold never outnumber the pairs counted
    a_over_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (over_threshold_count <= item_count))
        else $error("over_threshold_count above item_count");

    // The error sum covers at least its largest term
    a_sum_ge_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sum_abs_error >= SUM1_W'(max_abs_error)))
        else $error("sum_abs_error below max_abs_error");
`endif

endmodule

`default_nettype wire

>>> src/ena_diff.sv
// Input register and absolute difference / magnitude stage.
`default_nettype none

module ena_diff (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ena_pkg::SAMPLE_W-1:0]  first_value,
    input  logic signed [ena_pkg::SAMPLE_W-1:0]  second_value,
    input  logic                                 last_of_set,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ena_pkg::diff_t                       out_item
);
    import ena_pkg::*;

    logic                 in_valid_reg;
    sample_t              first_reg;
    sample_t              second_reg;
    logic                 last_reg;
    logic                 dif_valid_reg;
    diff_t                dif_reg;
    diff_t                dif_next;
    logic                 adv_in;
    logic                 adv_dif;
    logic signed [SAMPLE_W:0] d_wide;
    logic signed [SAMPLE_W:0] b_wide;
    logic        [SAMPLE_W:0] err_wide;
    logic        [SAMPLE_W:0] mag_wide;

    // Advance a stage when it is empty or its content moves on
    assign adv_dif  = !dif_valid_reg || out_ready;
    assign adv_in   = !in_valid_reg || adv_dif;
    assign in_ready = adv_in;

    // Form the absolute error and the reference magnitude
    always_comb
    begin
        d_wide   = {first_reg[SAMPLE_W-1], first_reg} - {second_reg[SAMPLE_W-1], second_reg};
        b_wide   = {second_reg[SAMPLE_W-1], second_reg};
        err_wide = d_wide[SAMPLE_W] ? $unsigned(-d_wide) : $unsigned(d_wide);
        mag_wide = b_wide[SAMPLE_W] ? $unsigned(-b_wide) : $unsigned(b_wide);
        dif_next.err    = err_wide[SAMPLE_W-1:0];
        dif_next.mag    = mag_wide[SAMPLE_W-1:0];
        dif_next.second = second_reg;
        dif_next.last   = last_reg;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            dif_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
            begin
                in_valid_reg <= in_valid;
            end
            if (adv_dif)
            begin
                dif_valid_reg <= in_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv_in)
        begin
            first_reg  <= first_value;
            second_reg <= second_value;
            last_reg   <= last_of_set;
        end
        if (adv_dif)
        begin
            dif_reg <= dif_next;
        end
    end

    assign out_valid = dif_valid_reg;
    assign out_item  = dif_reg;

endmodule

`default_nettype wire

>>> src/ena_prod.sv
// Product stage: squares and the two sides of the relative error test.
`default_nettype none

module ena_prod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ena_pkg::diff_t                in_item,
    input  logic [ena_pkg::THR_W-1:0]     threshold,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ena_pkg::prod_t                out_item
);
    import ena_pkg::*;

    logic  prod_valid_reg;
    prod_t prod_reg;
    prod_t prod_next;
    logic  adv_prod;

    assign adv_prod = !prod_valid_reg || out_ready;
    assign in_ready = adv_prod;

    // Multiply out the squares and the threshold products
    always_comb
    begin
        prod_next.err        = in_item.err;
        prod_next.mag        = in_item.mag;
        prod_next.second     = in_item.second;
        prod_next.err_sq     = SQ_W'(in_item.err) * SQ_W'(in_item.err);
        prod_next.mag_sq     = SQ_W'(in_item.mag) * SQ_W'(in_item.mag);
        prod_next.err_scaled = TEST_W'(in_item.err) * PCT_SCALE;
        prod_next.thr_mag    = TEST_W'(threshold) * TEST_W'(in_item.mag);
        prod_next.mag_zero   = (in_item.mag == '0);
        prod_next.thr_zero   = (threshold == '0);
        prod_next.last       = in_item.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (adv_prod)
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_item  = prod_reg;

endmodule

`default_nettype wire

>>> src/ena_accum.sv
// Accumulators, extremes, counters and the result register.
`default_nettype none

module ena_accum #(
    parameter int MAX_SET_ITEMS = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ena_pkg::prod_t    in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output ena_pkg::result_t  out_item
);
    import ena_pkg::*;

    localparam int CNT_W = $clog2(MAX_SET_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SET_ITEMS);

    umag_t             max_err_reg,  max_err_next;
    umag_t             max_mag_reg,  max_mag_next;
    logic [SUM1_W-1:0] abs_sum_reg,  abs_sum_next;
    logic [SUM2_W-1:0] sq_sum_reg,   sq_sum_next;
    logic [SUM1_W-1:0] mag_sum_reg,  mag_sum_next;
    logic [SUM2_W-1:0] sqm_sum_reg,  sqm_sum_next;
    sample_t           min_reg,      min_next;
    sample_t           max_reg,      max_next;
    logic [CNT_W-1:0]  pair_cnt_reg, pair_cnt_next;
    logic [CNT_W-1:0]  over_cnt_reg, over_cnt_next;
    logic              sat_reg,      sat_next;

    logic              res_valid_reg;
    result_t           res_reg;
    result_t           res_next;

    logic              take;
    logic              over;
    logic [SUM1_W:0]   abs_wide;
    logic [SUM2_W:0]   sq_wide;
    logic [SUM1_W:0]   mag_wide;
    logic [SUM2_W:0]   sqm_wide;
    logic              pair_full;
    logic              over_full;

    // Stall only a last transaction while the previous result is unclaimed
    assign in_ready = !in_item.last || !res_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Relative error test; a zero magnitude counts only at a zero threshold
    assign over = in_item.mag_zero ? in_item.thr_zero
                                   : (in_item.err_scaled >= in_item.thr_mag);

    // Compute updated statistics for the current transaction
    always_comb
    begin
        abs_wide  = {1'b0, abs_sum_reg} + (SUM1_W+1)'(in_item.err);
        sq_wide   = {1'b0, sq_sum_reg}  + (SUM2_W+1)'(in_item.err_sq);
        mag_wide  = {1'b0, mag_sum_reg} + (SUM1_W+1)'(in_item.mag);
        sqm_wide  = {1'b0, sqm_sum_reg} + (SUM2_W+1)'(in_item.mag_sq);
        pair_full = (pair_cnt_reg >= CNT_MAX);
        over_full = (over_cnt_reg >= CNT_MAX);

        max_err_next = (in_item.err > max_err_reg) ? in_item.err : max_err_reg;
        max_mag_next = (in_item.mag > max_mag_reg) ? in_item.mag : max_mag_reg;
        min_next     = (in_item.second < min_reg) ? in_item.second : min_reg;
        max_next     = (in_item.second > max_reg) ? in_item.second : max_reg;

        abs_sum_next = abs_wide[SUM1_W] ? '1 : abs_wide[SUM1_W-1:0];
        sq_sum_next  = sq_wide[SUM2_W]  ? '1 : sq_wide[SUM2_W-1:0];
        mag_sum_next = mag_wide[SUM1_W] ? '1 : mag_wide[SUM1_W-1:0];
        sqm_sum_next = sqm_wide[SUM2_W] ? '1 : sqm_wide[SUM2_W-1:0];

        pair_cnt_next = pair_full ? CNT_MAX : pair_cnt_reg + 1'b1;
        if (over)
        begin
            over_cnt_next = over_full ? CNT_MAX : over_cnt_reg + 1'b1;
        end
        else
        begin
            over_cnt_next = over_cnt_reg;
        end

        sat_next = sat_reg || abs_wide[SUM1_W] || sq_wide[SUM2_W] || mag_wide[SUM1_W]
                   || sqm_wide[SUM2_W] || pair_full || (over && over_full);

        res_next.max_abs_error        = max_err_next;
        res_next.max_magnitude        = max_mag_next;
        res_next.sum_abs_error        = abs_sum_next;
        res_next.sum_sq_error         = sq_sum_next;
        res_next.sum_magnitude        = mag_sum_next;
        res_next.sum_sq_magnitude     = sqm_sum_next;
        res_next.min_second           = min_next;
        res_next.max_second           = max_next;
        res_next.item_count           = CNT_OUT_W'(pair_cnt_next);
        res_next.over_threshold_count = CNT_OUT_W'(over_cnt_next);
        res_next.saturated            = sat_next;
    end

    // Update the accumulators; clear them after a last transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_err_reg  <= '0;
            max_mag_reg  <= '0;
            abs_sum_reg  <= '0;
            sq_sum_reg   <= '0;
            mag_sum_reg  <= '0;
            sqm_sum_reg  <= '0;
            min_reg      <= SAMPLE_MOST_POS;
            max_reg      <= SAMPLE_MOST_NEG;
            pair_cnt_reg <= '0;
            over_cnt_reg <= '0;
            sat_reg      <= 1'b0;
        end
        else if (take)
        begin
            if (in_item.last)
            begin
                max_err_reg  <= '0;
                max_mag_reg  <= '0;
                abs_sum_reg  <= '0;
                sq_sum_reg   <= '0;
                mag_sum_reg  <= '0;
                sqm_sum_reg  <= '0;
                min_reg      <= SAMPLE_MOST_POS;
                max_reg      <= SAMPLE_MOST_NEG;
                pair_cnt_reg <= '0;
                over_cnt_reg <= '0;
                sat_reg      <= 1'b0;
            end
            else
            begin
                max_err_reg  <= max_err_next;
                max_mag_reg  <= max_mag_next;
                abs_sum_reg  <= abs_sum_next;
                sq_sum_reg   <= sq_sum_next;
                mag_sum_reg  <= mag_sum_next;
                sqm_sum_reg  <= sqm_sum_next;
                min_reg      <= min_next;
                max_reg      <= max_next;
                pair_cnt_reg <= pair_cnt_next;
                over_cnt_reg <= over_cnt_next;
                sat_reg      <= sat_next;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take && in_item.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_item.last)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

endmodule

`default_nettype wire
